/* rtl/lsvm_pkg.sv */
// Shared types, constants and codes of the looped sample voice mixer.
package lsvm_pkg;

    localparam int MAX_SAMPLES = 16384;
    localparam int GAP         = 16;
    localparam int STORE_DEPTH = MAX_SAMPLES + 4 * GAP;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 36;
    localparam int IN_W        = 80;
    localparam int OUT_W       = 32;
    localparam int DIV_W       = 32;
    localparam int DVSR_W      = 15;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SETPOS = 2'd1,
        CMD_GEN    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_PING = 2'd2,
        MODE_RSVD = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_LENGTH = 3'd0,
        CFG_LOOP_START    = 3'd1,
        CFG_LOOP_END      = 3'd2,
        CFG_LOOP_MODE     = 3'd3,
        CFG_STEP_SIZE     = 3'd4,
        CFG_PANNING       = 3'd5,
        CFG_MIX_DIVIDER   = 3'd6,
        CFG_UNUSED        = 3'd7
    } t_cfg_reg;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_GAIN,
        S_GWAIT,
        S_VOL,
        S_PAN,
        S_RD,
        S_CHK,
        S_WSET,
        S_WWAIT,
        S_WFIX,
        S_RD2,
        S_MIX,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic in_ready;
        logic do_write;
        logic do_setpos;
        logic gain_start;
        logic mul_vol;
        logic mul_pan;
        logic rd;
        logic wrap_start;
        logic wrap_fix;
        logic mix;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_accept;
        t_cmd cmd;
        logic div_busy;
        logic byte_zero;
        logic out_full;
    } t_dp_status;

endpackage

/* rtl/lsvm_div.sv */
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
module lsvm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lsvm_pkg::DIV_W-1:0]   i_dividend,
    input  logic [lsvm_pkg::DVSR_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic [lsvm_pkg::DIV_W-1:0]   o_quotient,
    output logic [lsvm_pkg::DVSR_W-1:0]  o_remainder
);
    import lsvm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_W-1:0]    r_quo;
    logic [DVSR_W-1:0]   r_rem;
    logic [DVSR_W-1:0]   r_dvsr;
    logic [DVSR_W:0]     trial;
    logic                fits;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? DVSR_W'(trial - {1'b0, r_dvsr}) : trial[DVSR_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* rtl/lsvm_ctrl.sv */
// Controller state machine sequencing clear, write, set position and generate.
module lsvm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lsvm_pkg::t_dp_status  i_status,
    output lsvm_pkg::t_dp_cmd     o_cmd
);
    import lsvm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_status.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_status.in_accept) n_state = S_DEC;
            S_DEC:   n_state = (i_status.cmd == CMD_GEN) ? S_GAIN : S_IDLE;
            S_GAIN:  n_state = S_GWAIT;
            S_GWAIT: if (!i_status.div_busy) n_state = S_VOL;
            S_VOL:   n_state = S_PAN;
            S_PAN:   n_state = S_RD;
            S_RD:    n_state = S_CHK;
            S_CHK:   n_state = i_status.byte_zero ? S_WSET : S_MIX;
            S_WSET:  n_state = S_WWAIT;
            S_WWAIT: if (!i_status.div_busy) n_state = S_WFIX;
            S_WFIX:  n_state = S_RD2;
            S_RD2:   n_state = S_MIX;
            S_MIX:   n_state = S_OUT;
            S_OUT:   if (!i_status.out_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE:  o_cmd.in_ready = 1'b1;
            S_DEC: begin
                o_cmd.do_write  = (i_status.cmd == CMD_WRITE);
                o_cmd.do_setpos = (i_status.cmd == CMD_SETPOS);
            end
            S_GAIN:  o_cmd.gain_start = 1'b1;
            S_VOL:   o_cmd.mul_vol = 1'b1;
            S_PAN:   o_cmd.mul_pan = 1'b1;
            S_RD:    o_cmd.rd = 1'b1;
            S_WSET:  o_cmd.wrap_start = 1'b1;
            S_WFIX:  o_cmd.wrap_fix = 1'b1;
            S_RD2:   o_cmd.rd = 1'b1;
            S_MIX:   o_cmd.mix = 1'b1;
            S_OUT:   o_cmd.out_load = !i_status.out_full;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_no_reclear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clearing pass restarted without reset");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_status.out_full)
        else $error("result loaded over a waiting result");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.gain_start || o_cmd.wrap_start) |-> !i_status.div_busy)
        else $error("divider started while busy");
`endif

endmodule

/* rtl/lsvm_dp.sv */
// Datapath: configuration registers, sample store, position, wrap and mix arithmetic.
module lsvm_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lsvm_pkg::t_dp_cmd                i_cmd,
    output lsvm_pkg::t_dp_status             o_status,
    input  logic                             i_cfg_valid,
    input  logic [lsvm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lsvm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic [lsvm_pkg::IN_W-1:0]        i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lsvm_pkg::OUT_W-1:0]       o_out_data
);
    import lsvm_pkg::*;

    // configuration
    logic [14:0] r_len, r_lstart, r_lend;
    t_mode       r_mode;
    logic [35:0] r_step_size;
    logic [7:0]  r_pan;
    logic [8:0]  r_mdiv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= 15'd1;
            r_lstart    <= 15'd0;
            r_lend      <= 15'd1;
            r_mode      <= MODE_OFF;
            r_step_size <= '0;
            r_pan       <= 8'd128;
            r_mdiv      <= 9'd1;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SAMPLE_LENGTH: r_len       <= i_cfg_data[14:0];
                CFG_LOOP_START:    r_lstart    <= i_cfg_data[14:0];
                CFG_LOOP_END:      r_lend      <= i_cfg_data[14:0];
                CFG_LOOP_MODE:     r_mode      <= t_mode'(i_cfg_data[1:0]);
                CFG_STEP_SIZE:     r_step_size <= i_cfg_data[35:0];
                CFG_PANNING:       r_pan       <= i_cfg_data[7:0];
                CFG_MIX_DIVIDER:   r_mdiv      <= i_cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    // latched input transaction
    logic        in_accept;
    t_cmd        r_icmd;
    logic [13:0] r_ofs;
    logic [7:0]  r_ibyte;
    logic [8:0]  r_vl, r_vr;
    logic [15:0] r_mf, r_ms;

    assign in_accept = i_in_valid && i_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_icmd  <= t_cmd'(i_in_data[1:0]);
            r_ofs   <= i_in_data[15:2];
            r_ibyte <= i_in_data[23:16];
            r_vl    <= i_in_data[32:24];
            r_vr    <= i_in_data[41:33];
            r_mf    <= i_in_data[57:42];
            r_ms    <= i_in_data[73:58];
        end
    end

    // loop geometry
    logic        ping;
    logic [14:0] eff_start;
    logic        ge_start, ge_end;
    logic [15:0] gap_sum;

    assign ping      = (r_mode == MODE_PING);
    assign eff_start = (r_mode == MODE_FWD || r_mode == MODE_PING) ? r_lstart : r_lend;
    assign ge_start  = {1'b0, r_ofs} >= eff_start;
    assign ge_end    = {1'b0, r_ofs} >= r_lend;
    assign gap_sum   = (ge_start ? 16'(GAP) : 16'd0) + (ge_end ? 16'(GAP) : 16'd0);

    // sample store with clearing pass
    logic [7:0]        r_mem [STORE_DEPTH];
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data, coded;
    logic              wr_en;

    assign coded   = r_ibyte ^ 8'h80;
    assign wr_en   = i_cmd.clr_step || (i_cmd.do_write && ({1'b0, r_ofs} < r_len));
    assign wr_addr = i_cmd.clr_step ? r_clr_addr
                   : ADDR_W'({1'b0, r_ofs} + gap_sum + 16'(GAP));
    assign wr_data = i_cmd.clr_step ? 8'd0 : ((coded == 8'd0) ? 8'd1 : coded);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // position and step
    logic [63:0] r_pos, r_step;
    logic [31:0] ip;
    logic signed [32:0] rd_idx;
    logic        rd_ok;
    logic [7:0]  r_rdata;
    logic        r_rok;
    logic [7:0]  cur_byte;

    assign ip     = r_pos[63:32];
    assign rd_idx = signed'({ip[31], ip}) + signed'(33'(GAP));
    assign rd_ok  = !rd_idx[32] && (rd_idx < 33'(STORE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_idx[ADDR_W-1:0]];
            r_rok   <= rd_ok;
        end
    end

    assign cur_byte = r_rok ? r_rdata : 8'd0;

    // set position base and wrap arithmetic
    logic [14:0] base;
    logic [15:0] set_a;
    logic signed [33:0] p34, rpos34, padj, dlt, absd;
    logic        fwd, fwd_adj;
    logic signed [15:0] lraw;
    logic [14:0] llen;
    logic [14:0] r_llen;
    logic        r_fwd2;
    logic [14:0] of_sel;
    logic [16:0] new_p;

    assign base  = ({1'b0, r_ofs} < r_len) ? {1'b0, r_ofs}
                 : ((r_len != 15'd0) ? (r_len - 15'd1) : 15'd0);
    assign set_a = {1'b0, base} + gap_sum;

    assign p34     = signed'({{2{ip[31]}}, ip});
    assign rpos34  = signed'(34'(eff_start) + 34'(GAP));
    assign fwd     = !r_step[63];
    assign fwd_adj = fwd && (p34 < rpos34);
    assign padj    = fwd_adj ? (p34 + signed'(34'(GAP))) : p34;
    assign dlt     = padj - rpos34;
    assign absd    = dlt[33] ? -dlt : dlt;
    assign lraw    = signed'({1'b0, r_lend}) - signed'({1'b0, eff_start});
    assign llen    = (lraw <= 16'sd0) ? 15'd1 : lraw[14:0];

    // divider shared by gain and loop modulo
    logic              div_start, div_busy;
    logic [DIV_W-1:0]  div_dvd, div_quo;
    logic [DVSR_W-1:0] div_dvs, div_rem;

    assign div_start = i_cmd.gain_start || i_cmd.wrap_start;
    assign div_dvd   = i_cmd.wrap_start ? absd[DIV_W-1:0] : DIV_W'(256);
    assign div_dvs   = i_cmd.wrap_start ? llen
                     : DVSR_W'((r_mdiv == 9'd0) ? 9'd1 : r_mdiv);

    lsvm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dvs),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign of_sel = (r_fwd2 == ping) ? (r_llen - 15'd1 - div_rem) : div_rem;
    assign new_p  = 17'(eff_start) + 17'(GAP) + 17'(of_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_step <= '0;
        end else if (i_cmd.do_setpos) begin
            r_pos  <= {16'd0, set_a, 32'd0};
            r_step <= {28'd0, r_step_size};
        end else if (i_cmd.gain_start) begin
            r_pos <= r_pos + r_step;
        end else if (i_cmd.wrap_fix) begin
            r_pos[63:32] <= {15'd0, new_p};
            if (ping) begin
                r_step <= ~r_step + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wrap_start) begin
            r_fwd2 <= fwd && !fwd_adj;
            r_llen <= llen;
        end
    end

    // volume, pan and mix
    logic [8:0]  r_vol, r_vor;
    logic [17:0] pl, pr;
    logic [7:0]  pfac;
    logic [16:0] pp;
    logic signed [17:0] r_cl, r_cr;

    assign pl   = r_vl * div_quo[8:0];
    assign pr   = r_vr * div_quo[8:0];
    assign pfac = (r_pan < 8'h80) ? {r_pan[6:0], 1'b0} : {~r_pan[6:0], 1'b0};
    assign pp   = ((r_pan < 8'h80) ? r_vor : r_vol) * pfac;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_vol) begin
            r_vol <= pl[16:8];
            r_vor <= pr[16:8];
        end else if (i_cmd.mul_pan) begin
            if (r_pan < 8'h80) begin
                r_vor <= pp[16:8];
            end else begin
                r_vol <= pp[16:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_cl <= 18'(signed'(cur_byte) * signed'({1'b0, r_vol}));
            r_cr <= 18'(signed'(cur_byte) * signed'({1'b0, r_vor}));
        end
    end

    // result register
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= {r_ms + r_cl[15:0], r_mf + r_cr[15:0]};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    assign o_status.clr_last  = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));
    assign o_status.in_accept = in_accept;
    assign o_status.cmd       = r_icmd;
    assign o_status.div_busy  = div_busy;
    assign o_status.byte_zero = (cur_byte == 8'd0);
    assign o_status.out_full  = r_ovalid && !i_out_ready;

`ifndef SYNTHESIS
    a_clr_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_step |-> !in_accept)
        else $error("input accepted during clearing pass");
    a_wrap_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wrap_fix |=> (r_pos[63:49] == 15'd0))
        else $error("wrap left position outside store range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready && !i_cmd.out_load) |=> $stable(r_odata))
        else $error("waiting result changed");
`endif

endmodule

/* rtl/looped_sample_voice_mixer_unit.sv */
// Top level of the looped sample voice mixer: controller plus datapath.
//
//  channel   direction  handshake                     payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  i_s_axis_tdata[79:0]
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  o_m_axis_tdata[31:0]
//  cfg       in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// After reset the sample store is zeroed one entry a cycle, all 16448 entries,
// with s_axis tready low; configuration writes are taken throughout.
// Write and set position finish in the decode state; generate runs the 32-step
// shared divider for the gain and, when the voice wraps, for the loop modulo.
// One item is in work at a time; a result waits in the output register while
// the next item is accepted, and generate stalls at its end until it is free.
module looped_sample_voice_mixer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // command[1:0], sample_offset[15:2], sample_byte[23:16], volume_left[32:24],
    // volume_right[41:33], mix_in_first[57:42], mix_in_second[73:58], zero pad
    input  logic [lsvm_pkg::IN_W-1:0]        i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // mix_out_first[15:0], mix_out_second[31:16]
    output logic [lsvm_pkg::OUT_W-1:0]       o_m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsvm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lsvm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lsvm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = cmd.in_ready;

    lsvm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lsvm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_data   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
